// ----- rtl/core/avirp_pkg.sv -----
// Shared types, constants and field tables of the AVI RIFF header parser.
package avirp_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_JUNK = 32'h4a554e4b;
  localparam logic [31:0] TAG_LIST = 32'h4c495354;
  localparam logic [31:0] TAG_MOVI = 32'h6d6f7669;
  localparam logic [31:0] TAG_AVIH = 32'h61766968;
  localparam logic [31:0] TAG_DMLH = 32'h646d6c68;
  localparam logic [31:0] TAG_IDX1 = 32'h69647831;
  localparam logic [31:0] TAG_STRH = 32'h73747268;
  localparam logic [31:0] TAG_STRF = 32'h73747266;
  localparam logic [31:0] TAG_AUDS = 32'h61756473;
  localparam logic [31:0] TAG_VIDS = 32'h76696473;
  localparam logic [31:0] FORM_AVI = 32'h61766920;
  localparam logic [31:0] FORM_AVIX = 32'h61766978;
  localparam logic [63:0] USEC_PER_SEC = 64'd1000000;

  localparam logic [5:0] CODE_FPS = 6'd14;
  localparam logic [5:0] CODE_KBPS = 6'd15;
  localparam logic [5:0] CODE_NOT_RIFF = 6'd56;
  localparam logic [5:0] CODE_NOT_AVI = 6'd57;

  localparam logic [3:0] K_NONE = 4'd0;
  localparam logic [3:0] K_JUNK = 4'd1;
  localparam logic [3:0] K_LIST = 4'd2;
  localparam logic [3:0] K_AVIH = 4'd3;
  localparam logic [3:0] K_DMLH = 4'd4;
  localparam logic [3:0] K_IDX1 = 4'd5;
  localparam logic [3:0] K_STRH = 4'd6;
  localparam logic [3:0] K_STRF = 4'd7;
  localparam logic [3:0] K_OTHER = 4'd8;
  localparam logic [3:0] F_AVIH = 4'd9;
  localparam logic [3:0] F_VSTRH = 4'd10;
  localparam logic [3:0] F_ASTRH = 4'd11;
  localparam logic [3:0] F_VSTRF = 4'd12;
  localparam logic [3:0] F_ASTRF = 4'd13;

  typedef enum logic [1:0] {
    OP_PLAIN,
    OP_FPS,
    OP_KBPS
  } op_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [5:0]  field_code;
    logic [31:0] field_value;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic [1:0]  cnt;
    logic [5:0]  code0;
    logic [31:0] val0;
    logic [5:0]  code1;
    op_e         op1;
    logic [31:0] val1;
    logic        clear;
  } cmd_t;

  function automatic logic [2:0] field_size(input logic [3:0] kind, input logic [3:0] idx);
    logic [2:0] s;
    s = 3'd4;
    if (kind == F_VSTRF && (idx == 4'd3 || idx == 4'd4)) begin
      s = 3'd2;
    end
    if (kind == F_ASTRF && (idx == 4'd0 || idx == 4'd1 || idx == 4'd4 ||
                            idx == 4'd5 || idx == 4'd6)) begin
      s = 3'd2;
    end
    return s;
  endfunction

  function automatic logic field_be(input logic [3:0] kind, input logic [3:0] idx);
    return ((kind == F_VSTRH || kind == F_ASTRH) && idx == 4'd0) ||
           (kind == F_VSTRF && idx == 4'd5);
  endfunction

  function automatic logic [3:0] field_count(input logic [3:0] kind);
    logic [3:0] c;
    unique case (kind)
      F_AVIH: c = 4'd14;
      F_VSTRH, F_ASTRH, F_VSTRF: c = 4'd11;
      F_ASTRF: c = 4'd7;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

  function automatic logic [5:0] field_base(input logic [3:0] kind);
    logic [5:0] b;
    unique case (kind)
      F_VSTRH: b = 6'd16;
      F_ASTRH: b = 6'd27;
      F_VSTRF: b = 6'd38;
      F_ASTRF: b = 6'd49;
      default: b = 6'd0;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] kind_of(input logic [31:0] tag);
    logic [3:0] k;
    unique case (tag)
      TAG_JUNK: k = K_JUNK;
      TAG_LIST: k = K_LIST;
      TAG_AVIH: k = K_AVIH;
      TAG_DMLH: k = K_DMLH;
      TAG_IDX1: k = K_IDX1;
      TAG_STRH: k = K_STRH;
      TAG_STRF: k = K_STRF;
      default: k = K_OTHER;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] lower_word(input logic [31:0] w);
    logic [31:0] r;
    logic [7:0]  c;
    for (int i = 0; i < 4; i++) begin
      c = w[8*i +: 8];
      if (c >= 8'h41 && c <= 8'h5a) begin
        c = c + 8'h20;
      end
      r[8*i +: 8] = c;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/avirp_front.sv -----
// Byte parser that walks the RIFF chunks and queues result commands.
module avirp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  avirp_pkg::in_t in_data_i,
  input  logic           full_i,
  output logic           push_o,
  output avirp_pkg::cmd_t cmd_o
);
  import avirp_pkg::*;

  localparam logic [3:0] PH_RIFF = 4'd0;
  localparam logic [3:0] PH_RSIZE = 4'd1;
  localparam logic [3:0] PH_FORM = 4'd2;
  localparam logic [3:0] PH_CID = 4'd3;
  localparam logic [3:0] PH_CSIZE = 4'd4;
  localparam logic [3:0] PH_LTYPE = 4'd5;
  localparam logic [3:0] PH_STYPE = 4'd6;
  localparam logic [3:0] PH_FIELDS = 4'd7;
  localparam logic [3:0] PH_SKIP = 4'd8;
  localparam logic [3:0] PH_HALT = 4'd9;

  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_AUDIO = 2'd1;
  localparam logic [1:0] ST_VIDEO = 2'd2;

  logic [3:0]  phase_q, phase_d;
  logic [1:0]  bpos_q, bpos_d;
  logic [31:0] word_q, word_d;
  logic [3:0]  kind_q, kind_d;
  logic [31:0] clen_q, clen_d;
  logic [31:0] cons_q, cons_d;
  logic [3:0]  fidx_q, fidx_d;
  logic [1:0]  lst_q, lst_d;
  logic [31:0] skip_q, skip_d;

  logic        accept;
  cmd_t        cmd;

  assign in_ready_o = !full_i;
  assign accept = in_valid_i && !full_i;
  assign cmd_o = cmd;
  assign push_o = accept && (cmd.cnt != 2'd0 || cmd.clear);

  always_comb begin
    logic [7:0]  b;
    logic [2:0]  size;
    logic        be;
    logic [31:0] wn;
    logic        done;
    logic        do_skip;
    logic [31:0] scnt;
    logic [31:0] cons_n;
    logic [3:0]  fi;
    logic [31:0] len;
    phase_d = phase_q;
    bpos_d = bpos_q;
    word_d = word_q;
    kind_d = kind_q;
    clen_d = clen_q;
    cons_d = cons_q;
    fidx_d = fidx_q;
    lst_d = lst_q;
    skip_d = skip_q;
    cmd = '0;
    cmd.op1 = OP_PLAIN;
    do_skip = 1'b0;
    scnt = '0;
    cons_n = cons_q;
    fi = fidx_q;
    len = '0;
    b = in_data_i.data_byte;
    size = (phase_q == PH_FIELDS) ? field_size(kind_q, fidx_q) : 3'd4;
    be = (phase_q == PH_FIELDS) ? field_be(kind_q, fidx_q) : (phase_q != PH_CSIZE);
    wn = be ? {word_q[23:0], b} : (word_q | (32'(b) << {bpos_q, 3'b000}));
    done = ({1'b0, bpos_q} + 3'd1) >= size;
    if (phase_q <= PH_FIELDS) begin
      if (done) begin
        word_d = '0;
        bpos_d = '0;
      end else begin
        word_d = wn;
        bpos_d = bpos_q + 2'd1;
      end
    end
    unique case (phase_q)
      PH_HALT: begin
      end
      PH_SKIP: begin
        skip_d = (skip_q != 32'd0) ? skip_q - 32'd1 : 32'd0;
        if (skip_d == 32'd0) begin
          phase_d = PH_CID;
        end
      end
      PH_FIELDS: begin
        if (done) begin
          cons_n = cons_q + 32'(size);
          cons_d = cons_n;
          cmd.cnt = 2'd1;
          cmd.code0 = field_base(kind_q) + 6'(fidx_q);
          cmd.val0 = wn;
          if (kind_q == F_AVIH) begin
            if (fidx_q == 4'd1) begin
              cmd.val0 = {wn[28:0], 3'b000};
            end
            if (fidx_q == 4'd0) begin
              cmd.cnt = 2'd2;
              cmd.code1 = CODE_FPS;
              cmd.op1 = OP_FPS;
              cmd.val1 = wn;
            end else if (fidx_q == 4'd4) begin
              cmd.cnt = 2'd2;
              cmd.code1 = CODE_KBPS;
              cmd.op1 = OP_KBPS;
              cmd.val1 = wn;
            end
          end
          fi = fidx_q + 4'd1;
          if (kind_q == F_ASTRF) begin
            if (fi == 4'd5 && clen_q == 32'd14) begin
              cmd.cnt = 2'd2;
              cmd.code1 = field_base(kind_q) + 6'd5;
              cmd.val1 = 32'd8;
              fi = 4'd6;
            end
            if (fi == 4'd6 && clen_q <= 32'd16) begin
              fi = 4'd7;
            end
          end
          fidx_d = fi;
          if (fi >= field_count(kind_q)) begin
            do_skip = 1'b1;
            scnt = (clen_q > cons_n) ? clen_q - cons_n : 32'd0;
          end
        end
      end
      PH_RIFF: begin
        if (done) begin
          if (wn == TAG_RIFF) begin
            phase_d = PH_RSIZE;
          end else begin
            cmd.cnt = 2'd1;
            cmd.code0 = CODE_NOT_RIFF;
            cmd.val0 = wn;
            phase_d = PH_HALT;
          end
        end
      end
      PH_RSIZE: begin
        if (done) begin
          phase_d = PH_FORM;
        end
      end
      PH_FORM: begin
        if (done) begin
          if (lower_word(wn) == FORM_AVI || lower_word(wn) == FORM_AVIX) begin
            phase_d = PH_CID;
          end else begin
            cmd.cnt = 2'd1;
            cmd.code0 = CODE_NOT_AVI;
            cmd.val0 = wn;
            phase_d = PH_HALT;
          end
        end
      end
      PH_CID: begin
        if (done) begin
          kind_d = kind_of(wn);
          phase_d = PH_CSIZE;
        end
      end
      PH_CSIZE: begin
        if (done) begin
          clen_d = wn;
          cons_d = '0;
          unique case (kind_q)
            K_JUNK: begin
              do_skip = 1'b1;
              scnt = wn;
            end
            K_LIST: phase_d = PH_LTYPE;
            K_AVIH: begin
              kind_d = F_AVIH;
              fidx_d = '0;
              phase_d = PH_FIELDS;
            end
            K_DMLH, K_IDX1: begin
              len = wn + {31'd0, wn[0]};
              do_skip = 1'b1;
              scnt = len;
            end
            K_STRH: phase_d = PH_STYPE;
            K_STRF: begin
              if (lst_q == ST_VIDEO) begin
                kind_d = F_VSTRF;
                fidx_d = '0;
                phase_d = PH_FIELDS;
              end else if (lst_q == ST_AUDIO) begin
                kind_d = F_ASTRF;
                fidx_d = '0;
                phase_d = PH_FIELDS;
              end else begin
                do_skip = 1'b1;
                scnt = wn;
              end
            end
            default: begin
              kind_d = K_NONE;
              phase_d = PH_CID;
            end
          endcase
        end
      end
      PH_LTYPE: begin
        if (done) begin
          cons_d = 32'd4;
          if (wn == TAG_MOVI) begin
            do_skip = 1'b1;
            scnt = (clen_q > 32'd4) ? clen_q - 32'd4 : 32'd0;
          end else begin
            kind_d = K_NONE;
            phase_d = PH_CID;
          end
        end
      end
      PH_STYPE: begin
        if (done) begin
          cons_d = 32'd4;
          if (wn == TAG_AUDS) begin
            lst_d = ST_AUDIO;
            kind_d = F_ASTRH;
            fidx_d = '0;
            phase_d = PH_FIELDS;
          end else if (wn == TAG_VIDS) begin
            lst_d = ST_VIDEO;
            kind_d = F_VSTRH;
            fidx_d = '0;
            phase_d = PH_FIELDS;
          end else begin
            do_skip = 1'b1;
            scnt = (clen_q > 32'd4) ? clen_q - 32'd4 : 32'd0;
          end
        end
      end
      default: phase_d = PH_HALT;
    endcase
    if (do_skip) begin
      kind_d = K_NONE;
      if (scnt != 32'd0) begin
        skip_d = scnt;
        phase_d = PH_SKIP;
      end else begin
        phase_d = PH_CID;
      end
    end
    if (in_data_i.end_of_file) begin
      cmd.clear = 1'b1;
      phase_d = PH_RIFF;
      bpos_d = '0;
      word_d = '0;
      kind_d = K_NONE;
      clen_d = '0;
      cons_d = '0;
      fidx_d = '0;
      lst_d = ST_NONE;
      skip_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      bpos_q <= '0;
      word_q <= '0;
      kind_q <= K_NONE;
      clen_q <= '0;
      cons_q <= '0;
      fidx_q <= '0;
      lst_q <= ST_NONE;
      skip_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      bpos_q <= bpos_d;
      word_q <= word_d;
      kind_q <= kind_d;
      clen_q <= clen_d;
      cons_q <= cons_d;
      fidx_q <= fidx_d;
      lst_q <= lst_d;
      skip_q <= skip_d;
    end
  end

endmodule

// ----- rtl/core/avirp_queue.sv -----
// Short command queue between the parser and the result stage.
module avirp_queue #(
  parameter int unsigned Depth = avirp_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  avirp_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output avirp_pkg::cmd_t cmd_o
);
  import avirp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/avirp_back.sv -----
// Result stage: serializes queued results and computes the rate fields by division.
module avirp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [31:0]     cfg_wdata_i,
  input  logic            empty_i,
  input  avirp_pkg::cmd_t cmd_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output avirp_pkg::out_t out_data_o
);
  import avirp_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OUT0 = 3'd1;
  localparam logic [2:0] ST_MUL = 3'd2;
  localparam logic [2:0] ST_DIV = 3'd3;
  localparam logic [2:0] ST_OUT1 = 3'd4;

  logic [2:0]  state_q;
  cmd_t        cmd_q;
  logic [31:0] file_size_q;
  logic [31:0] fps_q;
  logic [31:0] kbps_q;
  logic [31:0] val1_q;
  logic [63:0] dq_q;
  logic [32:0] rem_q;
  logic [31:0] div_q;
  logic [5:0]  step_q;
  logic [32:0] rem_sh;
  logic        fit;
  logic [63:0] quo;

  assign pop_o = (state_q == ST_IDLE) && !empty_i;
  assign out_valid_o = (state_q == ST_OUT0) || (state_q == ST_OUT1);
  assign out_data_o.field_code = (state_q == ST_OUT1) ? cmd_q.code1 : cmd_q.code0;
  assign out_data_o.field_value = (state_q == ST_OUT1) ? val1_q : cmd_q.val0;
  assign out_data_o.last_of_run = (state_q == ST_OUT1) || (cmd_q.cnt == 2'd1);

  assign rem_sh = {rem_q[31:0], dq_q[63]};
  assign fit = rem_sh >= {1'b0, div_q};
  assign quo = {dq_q[62:0], fit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
    end else if (cfg_we_i) begin
      file_size_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fps_q <= '0;
      kbps_q <= '0;
      val1_q <= '0;
      dq_q <= '0;
      rem_q <= '0;
      div_q <= '0;
      step_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            if (cmd_i.cnt != 2'd0) begin
              state_q <= ST_OUT0;
            end else if (cmd_i.clear) begin
              fps_q <= '0;
              kbps_q <= '0;
            end
          end
        end
        ST_OUT0: begin
          if (out_ready_i) begin
            if (cmd_q.cnt == 2'd1) begin
              state_q <= ST_IDLE;
              if (cmd_q.clear) begin
                fps_q <= '0;
                kbps_q <= '0;
              end
            end else begin
              div_q <= cmd_q.val1;
              rem_q <= '0;
              step_q <= '0;
              unique case (cmd_q.op1)
                OP_FPS: begin
                  if (cmd_q.val1 == 32'd0) begin
                    fps_q <= '0;
                    val1_q <= '0;
                    state_q <= ST_OUT1;
                  end else begin
                    dq_q <= USEC_PER_SEC;
                    state_q <= ST_DIV;
                  end
                end
                OP_KBPS: begin
                  if (cmd_q.val1 == 32'd0) begin
                    val1_q <= kbps_q;
                    state_q <= ST_OUT1;
                  end else begin
                    state_q <= ST_MUL;
                  end
                end
                default: begin
                  val1_q <= cmd_q.val1;
                  state_q <= ST_OUT1;
                end
              endcase
            end
          end
        end
        ST_MUL: begin
          dq_q <= 64'(fps_q) * 64'(file_size_q);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= fit ? rem_sh - {1'b0, div_q} : rem_sh;
          dq_q <= quo;
          step_q <= step_q + 6'd1;
          if (step_q == 6'd63) begin
            if (cmd_q.op1 == OP_FPS) begin
              fps_q <= quo[31:0];
              val1_q <= quo[31:0];
            end else begin
              kbps_q <= quo[38:7];
              val1_q <= quo[38:7];
            end
            state_q <= ST_OUT1;
          end
        end
        ST_OUT1: begin
          if (out_ready_i) begin
            state_q <= ST_IDLE;
            if (cmd_q.clear) begin
              fps_q <= '0;
              kbps_q <= '0;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> div_q != 32'd0)
    else $error("divider running with a zero divisor");
  a_mul_kbps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> cmd_q.op1 == OP_KBPS)
    else $error("product formed for a command that is not a rate");
  a_second_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT1 |-> cmd_q.cnt == 2'd2)
    else $error("second beat for a single result command");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |=> !$past(pop_o))
    else $error("queue popped while busy");
`endif

endmodule

// ----- rtl/core/avi_riff_header_parser.sv -----
// Top level of the AVI RIFF header parser: parser, command queue and result stage.
// The parser takes one file byte per cycle while the command queue has room, and each
// byte that yields header fields leaves one command for the result stage, which sends
// one or two beats. A plain command is loaded from the queue and its beats are then sent
// in turn. The frames-per-second field goes through the shared 64-step restoring divider,
// and the kilobit rate first forms a product in the multiply state, then uses the divider;
// while they run, bytes keep entering until the queue is full. file_size must be written
// while the block is idle.
module avi_riff_header_parser #(
  parameter int unsigned QueueDepth = avirp_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [31:0]     cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  avirp_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output avirp_pkg::out_t out_data_o
);
  import avirp_pkg::*;

  logic push, full, pop, empty;
  cmd_t cmd_in, cmd_out;

  avirp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .full_i(full), .push_o(push), .cmd_o(cmd_in)
  );

  avirp_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(cmd_in), .full_o(full),
    .pop_i(pop), .empty_o(empty), .cmd_o(cmd_out)
  );

  avirp_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .empty_i(empty), .cmd_i(cmd_out),
    .pop_o(pop), .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
